// File: rtl/core/gpia_pkg.sv
// Shared types and constants for the gated photon image accumulator.
package gpia_pkg;

    localparam int POS_W      = 16;
    localparam int TIME_W     = 16;
    localparam int SIDE_W     = 9;
    localparam int OUT_CNT_W  = 32;
    localparam int OUT_SUM_W  = 48;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef enum logic [1:0] {
        REG_IMAGE_SIDE = 2'd0,
        REG_GATE_LOW   = 2'd1,
        REG_GATE_HIGH  = 2'd2
    } t_reg_idx;

    typedef enum logic {
        CMD_ACCUM = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

endpackage

// File: rtl/core/gated_photon_image_accumulator_core.sv
// Gated photon image accumulator: per-pixel saturating photon counts and time sums.
//
// Events enter on s_axis one per cycle and pass through a two-stage read-modify-write on a
// single synchronous pixel memory (read at accept, update and write back in the next cycle);
// a write-back register forwards the last update to a following event on the same pixel,
// so repeated pixels also sustain one event per cycle. A read command yields one beat on
// m_axis via the update stage and the result register; while a finished result waits
// unaccepted and the next read is ready, intake pauses. After reset the block sweeps all
// MAX_SIDE*MAX_SIDE memory entries to zero, one entry per cycle (65536 at the defaults),
// with s_axis_tready low during that pass; the APB registers can be written throughout.
module gated_photon_image_accumulator_core
    import gpia_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int COUNT_BITS = 32,
    parameter int SUM_BITS   = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // s_axis_tdata: pos_x[15:0], pos_y[31:16], arrival_time[47:32]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,
    // s_axis_tuser: cmd[0]
    input  logic [0:0]            s_axis_tuser,
    // m_axis_tdata: count[31:0], time_sum[79:32]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [79:0]           m_axis_tdata,
    // m_axis_tuser: out_of_range[0]
    output logic [0:0]            m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PIXELS  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int COORD_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int WORD_W  = COUNT_BITS + SUM_BITS;

    // configuration
    logic [SIDE_W-1:0] r_image_side;
    logic [TIME_W-1:0] r_gate_low;
    logic [TIME_W-1:0] r_gate_high;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    // control
    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              clr_active;
    logic              clr_last;

    // pixel memory
    logic [WORD_W-1:0] mem [PIXELS];
    logic [WORD_W-1:0] r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [WORD_W-1:0] mem_wd;

    // input decode
    logic              in_accept;
    logic [POS_W-1:0]  in_x;
    logic [POS_W-1:0]  in_y;
    logic [TIME_W-1:0] in_time;
    logic [POS_W-1:0]  side_eff;
    logic [POS_W-1:0]  xm1;
    logic [POS_W-1:0]  ym1;
    logic              in_inside;
    logic              in_keep;
    logic [ADDR_W-1:0] in_addr;

    // update stage
    logic              r_pend_wr;
    logic              r_pend_rd;
    logic              r_pend_inside;
    logic [ADDR_W-1:0] r_pend_addr;
    logic [TIME_W-1:0] r_pend_time;
    logic              advance;

    // forwarding
    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr;
    logic [WORD_W-1:0] r_wb_data;

    logic [WORD_W-1:0]     cur_word;
    logic [COUNT_BITS-1:0] cur_count;
    logic [SUM_BITS-1:0]   cur_sum;
    logic [COUNT_BITS-1:0] new_count;
    logic [SUM_BITS:0]     sum_ext;
    logic [SUM_BITS-1:0]   new_sum;
    logic [63:0]           cnt_wide;
    logic [63:0]           sum_wide;

    // result register
    logic                 r_out_valid;
    logic [OUT_CNT_W-1:0] r_out_count;
    logic [OUT_SUM_W-1:0] r_out_sum;
    logic                 r_out_oor;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_side <= SIDE_W'(256);
            r_gate_low   <= '0;
            r_gate_high  <= '1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_SIDE: r_image_side <= pwdata[SIDE_W-1:0];
                REG_GATE_LOW:   r_gate_low   <= pwdata[TIME_W-1:0];
                REG_GATE_HIGH:  r_gate_high  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_SIDE: prdata = APB_DATA_W'(r_image_side);
            REG_GATE_LOW:   prdata = APB_DATA_W'(r_gate_low);
            REG_GATE_HIGH:  prdata = APB_DATA_W'(r_gate_high);
            default:        prdata = '0;
        endcase
    end

    // ---------------- clearing pass ----------------
    assign clr_last = (r_clr_addr == ADDR_W'(PIXELS - 1));

    always_comb begin
        case (r_state)
            ST_CLEAR: n_state = clr_last ? ST_RUN : ST_CLEAR;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: clr_active = 1'b1;
            ST_RUN:   clr_active = 1'b0;
            default:  clr_active = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_active && !clr_last) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // ---------------- input decode ----------------
    assign in_x    = s_axis_tdata[15:0];
    assign in_y    = s_axis_tdata[31:16];
    assign in_time = s_axis_tdata[47:32];

    assign side_eff  = (POS_W'(r_image_side) > POS_W'(MAX_SIDE)) ? POS_W'(MAX_SIDE)
                                                                 : POS_W'(r_image_side);
    assign in_inside = (in_x != '0) && (in_y != '0) && (in_x <= side_eff)
                       && (in_y <= side_eff);
    assign in_keep   = (in_time >= r_gate_low) && (in_time <= r_gate_high);
    assign xm1       = in_x - POS_W'(1);
    assign ym1       = in_y - POS_W'(1);
    assign in_addr   = ADDR_W'(ym1[COORD_W-1:0]) * ADDR_W'(MAX_SIDE)
                       + ADDR_W'(xm1[COORD_W-1:0]);

    assign advance       = !(r_pend_rd && r_out_valid && !m_axis_tready);
    assign s_axis_tready = !clr_active && advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ---------------- update stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_wr <= 1'b0;
            r_pend_rd <= 1'b0;
        end else if (advance) begin
            r_pend_wr <= in_accept && (t_cmd'(s_axis_tuser[0]) == CMD_ACCUM)
                         && in_inside && in_keep;
            r_pend_rd <= in_accept && (t_cmd'(s_axis_tuser[0]) == CMD_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pend_inside <= in_inside;
            r_pend_addr   <= in_addr;
            r_pend_time   <= in_time;
        end
    end

    assign cur_word  = (r_wb_valid && (r_wb_addr == r_pend_addr)) ? r_wb_data : r_rd_data;
    assign cur_count = cur_word[COUNT_BITS-1:0];
    assign cur_sum   = cur_word[WORD_W-1:COUNT_BITS];

    assign new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);
    assign sum_ext   = {1'b0, cur_sum} + (SUM_BITS + 1)'(r_pend_time);
    assign new_sum   = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];

    // ---------------- pixel memory ----------------
    assign mem_we = clr_active || r_pend_wr;
    assign mem_wa = clr_active ? r_clr_addr : r_pend_addr;
    assign mem_wd = clr_active ? '0 : {new_sum, new_count};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (in_accept) begin
            r_rd_data <= mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (r_pend_wr) begin
            r_wb_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_wr) begin
            r_wb_addr <= r_pend_addr;
            r_wb_data <= {new_sum, new_count};
        end
    end

    // ---------------- result register ----------------
    assign cnt_wide = 64'(cur_count);
    assign sum_wide = 64'(cur_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend_rd && advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_rd && advance) begin
            if (r_pend_inside) begin
                r_out_count <= (cnt_wide > 64'({OUT_CNT_W{1'b1}})) ? '1
                                                                   : cnt_wide[OUT_CNT_W-1:0];
                r_out_sum   <= (sum_wide > 64'({OUT_SUM_W{1'b1}})) ? '1
                                                                   : sum_wide[OUT_SUM_W-1:0];
                r_out_oor   <= 1'b0;
            end else begin
                r_out_count <= '0;
                r_out_sum   <= '0;
                r_out_oor   <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out_sum, r_out_count};
    assign m_axis_tuser[0] = r_out_oor;

    // ---------------- assertions ----------------
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_active |-> !r_pend_wr && !r_pend_rd)
        else $error("pixel update pending during clearing pass");

    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && ($past(r_state) == ST_CLEAR)
        |-> $past(r_clr_addr) == ADDR_W'(PIXELS - 1))
        else $error("clearing pass ended before last entry");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_rd && r_out_valid && !m_axis_tready |=> r_pend_rd && r_out_valid)
        else $error("pending read result lost while output stalled");

endmodule

// File: dv/tb_gated_photon_image_accumulator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the gated photon image accumulator core.
module tb_gated_photon_image_accumulator_core;
    import gpia_pkg::*;

    localparam int MAX_SIDE      = 256;
    localparam int COUNT_BITS    = 32;
    localparam int SUM_BITS      = 48;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOT_PIXELS    = 8;

    typedef struct {
        t_cmd              cmd;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [TIME_W-1:0] arrival;
    } t_photon_beat;

    typedef struct {
        logic [OUT_CNT_W-1:0] count;
        logic [OUT_SUM_W-1:0] time_sum;
        logic                 out_of_range;
    } t_pixel_readout;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // pos_x[15:0], pos_y[31:16], arrival_time[47:32]
    logic [47:0]           s_axis_tdata = '0;
    // cmd[0]
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // count[31:0], time_sum[79:32]
    logic [79:0]           m_axis_tdata;
    // out_of_range[0]
    logic [0:0]            m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Expected image contents and register copies
    logic [COUNT_BITS-1:0] photon_tally [int unsigned];
    logic [SUM_BITS-1:0]   arrival_total [int unsigned];
    logic [SIDE_W-1:0]     side_reg = 9'd256;
    logic [TIME_W-1:0]     gate_lo_reg = '0;
    logic [TIME_W-1:0]     gate_hi_reg = '1;

    t_photon_beat          beat_queue [$];
    t_pixel_readout        readout_queue [$];
    t_photon_beat          tx_beat;
    logic [POS_W-1:0]      hot_x [HOT_PIXELS];
    logic [POS_W-1:0]      hot_y [HOT_PIXELS];
    int                    errors = 0;
    int                    tx_gap = 0;
    int                    tx_burst = 0;
    bit                    tx_idle = 1'b0;
    int                    rx_gap = 0;
    int                    rx_burst = 0;
    bit                    rx_idle = 1'b0;

    gated_photon_image_accumulator_core #(
        .MAX_SIDE   (MAX_SIDE),
        .COUNT_BITS (COUNT_BITS),
        .SUM_BITS   (SUM_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_side();
        return (side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg);
    endfunction

    // Alternate stretches of random waits and stretches of back-to-back beats
    function automatic int draw_wait(inout int burst, inout bit idle);
        if (burst == 0) begin
            burst = $urandom_range(8, 40);
            idle = ($urandom_range(0, 2) != 0);
        end
        burst--;
        return idle ? $urandom_range(0, 3) : 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Update the expected image, or queue the expected readout
    task automatic apply_beat(input t_photon_beat b);
        int unsigned           side;
        int unsigned           addr;
        bit                    in_image;
        logic [COUNT_BITS-1:0] cnt;
        logic [SUM_BITS:0]     sum;
        t_pixel_readout        r;
        side = clamp_side();
        in_image = (b.pos_x != 0) && (b.pos_y != 0) && (b.pos_x <= side) && (b.pos_y <= side);
        addr = (b.pos_y - 1) * MAX_SIDE + (b.pos_x - 1);
        cnt = photon_tally.exists(addr) ? photon_tally[addr] : '0;
        sum = arrival_total.exists(addr) ? {1'b0, arrival_total[addr]} : '0;
        if (b.cmd == CMD_ACCUM) begin
            if (in_image && b.arrival >= gate_lo_reg && b.arrival <= gate_hi_reg) begin
                photon_tally[addr] = (&cnt) ? cnt : cnt + 1'b1;
                sum = sum + b.arrival;
                arrival_total[addr] = sum[SUM_BITS] ? '1 : sum[SUM_BITS-1:0];
            end
        end else begin
            if (in_image) begin
                r.count = cnt;
                r.time_sum = sum[SUM_BITS-1:0];
                r.out_of_range = 1'b0;
            end else begin
                r.count = '0;
                r.time_sum = '0;
                r.out_of_range = 1'b1;
            end
            readout_queue.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        logic next_valid;
        next_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_beat(tx_beat);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (beat_queue.size() != 0) begin
                    tx_beat = beat_queue.pop_front();
                    s_axis_tdata <= {tx_beat.arrival, tx_beat.pos_y, tx_beat.pos_x};
                    s_axis_tuser <= tx_beat.cmd;
                    next_valid = 1'b1;
                    tx_gap = draw_wait(tx_burst, tx_idle);
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    always @(posedge i_clk) begin
        t_pixel_readout want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (readout_queue.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
                end else begin
                    want = readout_queue.pop_front();
                    if (m_axis_tdata[31:0] !== want.count)
                        report_mismatch("count", m_axis_tdata[31:0], want.count);
                    if (m_axis_tdata[79:32] !== want.time_sum)
                        report_mismatch("time_sum", m_axis_tdata[79:32], want.time_sum);
                    if (m_axis_tuser[0] !== want.out_of_range)
                        report_mismatch("out_of_range", m_axis_tuser[0], want.out_of_range);
                end
                rx_gap = draw_wait(rx_burst, rx_idle);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            m_axis_tready <= (rx_gap == 0);
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_SIDE: side_reg = value[SIDE_W-1:0];
            REG_GATE_LOW:   gate_lo_reg = value[TIME_W-1:0];
            REG_GATE_HIGH:  gate_hi_reg = value[TIME_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every readout has arrived and the pipeline has drained
    task automatic wait_idle();
        @(negedge i_clk);
        while (beat_queue.size() != 0 || s_axis_tvalid || readout_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers with junk above each field, then pick hot pixels
    task automatic configure(input int side, input int lo, input int hi);
        int span;
        wait_idle();
        write_reg(REG_IMAGE_SIDE, (32'($urandom()) << SIDE_W) | 32'(side));
        write_reg(REG_GATE_LOW, (32'($urandom()) << TIME_W) | 32'(lo));
        write_reg(REG_GATE_HIGH, (32'($urandom()) << TIME_W) | 32'(hi));
        @(negedge i_clk);
        span = (clamp_side() == 0) ? 4 : clamp_side();
        for (int i = 0; i < HOT_PIXELS; i++) begin
            hot_x[i] = POS_W'($urandom_range(1, span));
            hot_y[i] = POS_W'($urandom_range(1, span));
        end
        hot_x[0] = POS_W'(span);
        hot_y[0] = POS_W'(span);
    endtask

    task automatic add_beat(input t_cmd cmd, input int x, input int y, input int t);
        t_photon_beat b;
        b.cmd = cmd;
        b.pos_x = POS_W'(x);
        b.pos_y = POS_W'(y);
        b.arrival = TIME_W'(t);
        beat_queue.push_back(b);
    endtask

    function automatic logic [POS_W-1:0] border_coord(input int unsigned side);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return POS_W'(1);
            2:       return POS_W'(side);
            default: return POS_W'(side + 1);
        endcase
    endfunction

    function automatic t_photon_beat random_beat();
        t_photon_beat b;
        int unsigned  side;
        int           k;
        int           h;
        side = (clamp_side() == 0) ? 4 : clamp_side();
        b.cmd = ($urandom_range(0, 9) < 3) ? CMD_READ : CMD_ACCUM;
        k = $urandom_range(0, 19);
        h = $urandom_range(0, HOT_PIXELS - 1);
        if (k < 10) begin
            b.pos_x = hot_x[h];
            b.pos_y = hot_y[h];
        end else if (k < 15) begin
            b.pos_x = POS_W'($urandom_range(1, side));
            b.pos_y = POS_W'($urandom_range(1, side));
        end else if (k < 17) begin
            b.pos_x = border_coord(side);
            b.pos_y = border_coord(side);
        end else begin
            b.pos_x = POS_W'($urandom());
            b.pos_y = POS_W'($urandom());
        end
        k = $urandom_range(0, 9);
        if (k < 6) begin
            b.arrival = TIME_W'($urandom());
        end else if (k < 8) begin
            case ($urandom_range(0, 3))
                0:       b.arrival = gate_lo_reg - 1'b1;
                1:       b.arrival = gate_lo_reg;
                2:       b.arrival = gate_hi_reg;
                default: b.arrival = gate_hi_reg + 1'b1;
            endcase
        end else begin
            b.arrival = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return b;
    endfunction

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
            beat_queue.push_back(random_beat());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(256, 0, 65535);
        add_beat(CMD_ACCUM, 1, 1, 0);
        add_beat(CMD_ACCUM, 1, 1, 65535);
        add_beat(CMD_READ, 1, 1, 0);
        add_beat(CMD_ACCUM, 256, 256, 12345);
        add_beat(CMD_READ, 256, 256, 65535);
        add_beat(CMD_ACCUM, 0, 5, 100);
        add_beat(CMD_READ, 0, 5, 0);
        add_beat(CMD_READ, 257, 1, 0);
        add_beat(CMD_ACCUM, 65535, 65535, 1);
        add_beat(CMD_READ, 65535, 65535, 65535);
        add_beat(CMD_ACCUM, 7, 9, 1000);
        add_beat(CMD_ACCUM, 7, 9, 2000);
        add_beat(CMD_ACCUM, 7, 9, 3000);
        add_beat(CMD_READ, 7, 9, 0);
        add_random(300);

        configure(16, 100, 40000);
        add_random(250);

        configure(1, 0, 65535);
        add_random(100);

        configure(0, 0, 65535);
        add_beat(CMD_ACCUM, 1, 1, 5);
        add_beat(CMD_READ, 1, 1, 0);
        add_random(100);

        configure(511, 0, 65535);
        add_beat(CMD_ACCUM, 256, 256, 9);
        add_beat(CMD_READ, 256, 256, 0);
        add_beat(CMD_READ, 257, 257, 0);
        add_random(200);

        configure(16, 500, 499);
        add_beat(CMD_ACCUM, 2, 2, 500);
        add_beat(CMD_READ, 2, 2, 0);
        add_random(150);

        configure(4, 777, 777);
        add_beat(CMD_ACCUM, 3, 3, 777);
        add_beat(CMD_ACCUM, 3, 3, 778);
        add_beat(CMD_READ, 3, 3, 0);
        add_beat(CMD_READ, 256, 256, 0);
        add_random(150);

        configure(3, 65535, 65535);
        add_random(150);

        configure(256, 0, 65535);
        add_random(300);

        configure(200, 20000, 65535);
        add_random(150);

        wait_idle();
        if (errors == 0 && readout_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule
